// ===== rtl/u2a_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function for the digit printer.
`default_nettype none
package u2a_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIGITS_W   = NUM_DIGITS * DIGIT_W;
  localparam int unsigned BITCNT_W   = $clog2(VALUE_W);

  // Format codes on the mode input
  localparam logic [1:0] MODE_DEC     = 2'd0;
  localparam logic [1:0] MODE_HEX_LO  = 2'd1;
  localparam logic [1:0] MODE_HEX_UP  = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  // Most significant digit position for each base
  localparam logic [3:0] DEC_TOP_IDX = 4'd9;
  localparam logic [3:0] HEX_TOP_IDX = 4'd7;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // capture a new value and mode
    logic dabble;       // one shift-add-3 step of the binary to BCD conversion
    logic idx_dec;      // move to the next lower digit
    logic latch_total;  // record the character count
    logic emit;         // a digit beat is on the result ports
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_done;    // the step taken now is the last conversion step
    logic top_zero;     // current digit is a leading zero that can be dropped
    logic idx_zero;     // current digit is the least significant one
  } status_t;

  // Map one digit to its ASCII code
  function automatic logic [7:0] ascii_digit(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'd0, d};
    if (d < 4'd10) begin
      return ASCII_ZERO + d8;
    end
    return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + d8 - 8'd10;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/u2a_datapath.sv =====
// Datapath: shift-add-3 BCD converter, digit register, digit pointer and ASCII output.
`default_nettype none
module u2a_datapath (
  input  wire logic                        clk,
  input  wire logic [u2a_pkg::VALUE_W-1:0] value,
  input  wire logic [1:0]                  mode,
  input  wire u2a_pkg::cmd_t               cmd,
  output u2a_pkg::status_t                 status,
  output logic [7:0]                       char_code,
  output logic                             has_char,
  output logic                             last,
  output logic [3:0]                       char_count
);

  logic [u2a_pkg::VALUE_W-1:0]  shreg;
  logic [u2a_pkg::DIGITS_W-1:0] digits;
  logic [u2a_pkg::DIGITS_W-1:0] digits_adj;
  logic [u2a_pkg::BITCNT_W-1:0] bit_cnt;
  logic [1:0]                   mode_q;
  logic [3:0]                   idx;
  logic [3:0]                   total;
  logic [3:0]                   cur_digit;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < u2a_pkg::NUM_DIGITS; i++) begin
      if (digits[i*u2a_pkg::DIGIT_W +: u2a_pkg::DIGIT_W] >= 4'd5) begin
        digits_adj[i*u2a_pkg::DIGIT_W +: u2a_pkg::DIGIT_W] =
          digits[i*u2a_pkg::DIGIT_W +: u2a_pkg::DIGIT_W] + 4'd3;
      end else begin
        digits_adj[i*u2a_pkg::DIGIT_W +: u2a_pkg::DIGIT_W] =
          digits[i*u2a_pkg::DIGIT_W +: u2a_pkg::DIGIT_W];
      end
    end
  end

  // Select the digit under the pointer
  always_comb begin
    cur_digit = 4'd0;
    for (int i = 0; i < u2a_pkg::NUM_DIGITS; i++) begin
      if (idx == 4'(i)) begin
        cur_digit = digits[i*u2a_pkg::DIGIT_W +: u2a_pkg::DIGIT_W];
      end
    end
  end

  // Load, convert, and walk the digits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg   <= value;
      mode_q  <= mode;
      bit_cnt <= '0;
      if (mode == u2a_pkg::MODE_DEC) begin
        digits <= '0;
        idx    <= u2a_pkg::DEC_TOP_IDX;
      end else begin
        digits <= {{(u2a_pkg::DIGITS_W - u2a_pkg::VALUE_W){1'b0}}, value};
        idx    <= u2a_pkg::HEX_TOP_IDX;
      end
    end else begin
      if (cmd.dabble) begin
        digits  <= {digits_adj[u2a_pkg::DIGITS_W-2:0], shreg[u2a_pkg::VALUE_W-1]};
        shreg   <= {shreg[u2a_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + u2a_pkg::BITCNT_W'(1);
      end
      if (cmd.idx_dec) begin
        idx <= idx - 4'd1;
      end
      if (cmd.latch_total) begin
        total <= idx + 4'd1;
      end
    end
  end

  // Report status
  always_comb begin
    status.conv_done = (bit_cnt == u2a_pkg::BITCNT_W'(u2a_pkg::VALUE_W - 1));
    status.idx_zero  = (idx == 4'd0);
    status.top_zero  = (cur_digit == 4'd0) && (idx != 4'd0);
  end

  // Drive the result beat; outside a digit beat it is the empty beat
  always_comb begin
    char_code  = 8'd0;
    has_char   = 1'b0;
    last       = 1'b1;
    char_count = 4'd0;
    if (cmd.emit) begin
      char_code  = u2a_pkg::ascii_digit(cur_digit, mode_q == u2a_pkg::MODE_HEX_UP);
      has_char   = 1'b1;
      last       = (idx == 4'd0);
      char_count = (idx == 4'd0) ? total : 4'd0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u2a_ctrl.sv =====
// Controller: sequences load, conversion, leading-zero scan and digit beats.
`default_nettype none
module u2a_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       mode,
  input  wire u2a_pkg::status_t status,
  output u2a_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  strobe
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_NONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (mode == u2a_pkg::MODE_UNKNOWN) begin
            state_next = ST_NONE;
          end else if (mode == u2a_pkg::MODE_DEC) begin
            state_next = ST_CONV;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (status.conv_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Drop leading zeros, keep at least one digit
        if (status.top_zero) begin
          cmd.idx_dec = 1'b1;
        end else begin
          cmd.latch_total = 1'b1;
          state_next      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.idx_dec = 1'b1;
        if (status.idx_zero) begin
          state_next = ST_IDLE;
        end
      end
      ST_NONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign strobe = (state == ST_EMIT) || (state == ST_NONE);

endmodule
`default_nettype wire

// ===== rtl/unsigned_to_ascii_digits.sv =====
// Top level: 32-bit unsigned to decimal or hex ASCII digits, one beat per digit.
// Decimal runs the shift-add-3 conversion first, hex skips it; a scan then drops leading
// zeros, keeping at least one digit, then one beat per digit, most significant first.
// An unknown mode gives a single empty beat. The next item is taken the cycle after the
// last beat, so a new item is never taken before the last one is through.
// Synchronous active-high rst returns the controller to idle; the receiver cannot stall.
`default_nettype none
module unsigned_to_ascii_digits (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [u2a_pkg::VALUE_W-1:0] value,
  input  wire logic [1:0]                  mode,
  output logic                             strobe,
  output logic [7:0]                       char_code,
  output logic                             has_char,
  output logic                             last,
  output logic [3:0]                       char_count
);

  u2a_pkg::cmd_t    cmd;
  u2a_pkg::status_t status;

  u2a_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode    (mode),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .strobe  (strobe)
  );

  u2a_datapath u_dp (
    .clk        (clk),
    .value      (value),
    .mode       (mode),
    .cmd        (cmd),
    .status     (status),
    .char_code  (char_code),
    .has_char   (has_char),
    .last       (last),
    .char_count (char_count)
  );

`ifndef SYNTH
  // A beat only comes out while an item is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result beat while idle");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // Only the final beat of an item carries a count
  a_count_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (has_char && char_count == 4'd0))
    else $error("count or empty beat before the final beat");

  // A final digit beat reports a nonzero count of at most ten
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (strobe && last && has_char) |-> (char_count != 4'd0 && char_count <= 4'd10))
    else $error("bad character count on final beat");
`endif

endmodule
`default_nettype wire
